/* rtl/aes_pkg.sv */
// Package for the AES-256 block-mode engine: widths, codes, state type,
// S-box tables and round functions. No dependencies.
`default_nettype none
package aes_pkg;

    localparam int ROUND_COUNT = 14;
    localparam int KEY_WORDS   = 4 * (ROUND_COUNT + 1);
    localparam int KEY_ROWS    = ROUND_COUNT + 1;
    localparam int ROW_W       = $clog2(KEY_ROWS);
    localparam int KIDX_W      = $clog2(KEY_WORDS);
    localparam int PADDR_W     = 6;

    typedef enum logic [2:0] {
        MODE_ECB_ENC = 3'd0,
        MODE_ECB_DEC = 3'd1,
        MODE_CBC_ENC = 3'd2,
        MODE_CBC_DEC = 3'd3,
        MODE_CTR     = 3'd4,
        MODE_OFB     = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        REG_KEY0    = 3'd0,
        REG_KEY1    = 3'd1,
        REG_KEY2    = 3'd2,
        REG_KEY3    = 3'd3,
        REG_IV_HIGH = 3'd4,
        REG_IV_LOW  = 3'd5,
        REG_MODE    = 3'd6
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KROW0,
        ST_KROW1,
        ST_KEXP,
        ST_PRE,
        ST_INIT,
        ST_ROUND,
        ST_DONE
    } t_state;

    localparam logic [2047:0] FWD_SBOX = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] INV_SBOX = {
        128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return FWD_SBOX[2047 - 8 * int'(x) -: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        return INV_SBOX[2047 - 8 * int'(x) -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h00;
        p = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) r = r ^ p;
            p = xtime(p);
        end
        return r;
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [127:0] byte_sub_rows(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] = sbox(s[127 - 8 * (4 * ((c + r) & 3) + r) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_byte_sub_rows(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] =
                    inv_sbox(s[127 - 8 * (4 * ((c - r + 4) & 3) + r) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            t[127 - 32 * c -: 8] = gmul(a0, 4'h2) ^ gmul(a1, 4'h3) ^ a2 ^ a3;
            t[119 - 32 * c -: 8] = a0 ^ gmul(a1, 4'h2) ^ gmul(a2, 4'h3) ^ a3;
            t[111 - 32 * c -: 8] = a0 ^ a1 ^ gmul(a2, 4'h2) ^ gmul(a3, 4'h3);
            t[103 - 32 * c -: 8] = gmul(a0, 4'h3) ^ a1 ^ a2 ^ gmul(a3, 4'h2);
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            t[127 - 32 * c -: 8] = gmul(a0, 4'he) ^ gmul(a1, 4'hb) ^ gmul(a2, 4'hd) ^ gmul(a3, 4'h9);
            t[119 - 32 * c -: 8] = gmul(a0, 4'h9) ^ gmul(a1, 4'he) ^ gmul(a2, 4'hb) ^ gmul(a3, 4'hd);
            t[111 - 32 * c -: 8] = gmul(a0, 4'hd) ^ gmul(a1, 4'h9) ^ gmul(a2, 4'he) ^ gmul(a3, 4'hb);
            t[103 - 32 * c -: 8] = gmul(a0, 4'hb) ^ gmul(a1, 4'hd) ^ gmul(a2, 4'h9) ^ gmul(a3, 4'he);
        end
        return t;
    endfunction

endpackage
`default_nettype wire

/* rtl/aes_blk_if.sv */
// Input block channel: valid/ready handshake with one 128-bit block per beat.
// Depends on nothing.
`default_nettype none
interface aes_blk_if;
    logic        valid;
    logic        ready;
    logic        first_block;
    logic [63:0] block_high;
    logic [63:0] block_low;

    modport source (output valid, first_block, block_high, block_low, input ready);
    modport sink   (input valid, first_block, block_high, block_low, output ready);
endinterface
`default_nettype wire

/* rtl/aes_res_if.sv */
// Result block channel: valid/ready handshake with one 128-bit block per beat.
// Depends on nothing.
`default_nettype none
interface aes_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_high;
    logic [63:0] out_low;

    modport source (output valid, out_high, out_low, input ready);
    modport sink   (input valid, out_high, out_low, output ready);
endinterface
`default_nettype wire

/* rtl/aes256_block_modes.sv */
// AES-256 engine for ECB, CBC, CTR and OFB, one round per cycle.
// Depends on aes_pkg, aes_blk_if and aes_res_if.
//
// Channels: i_blk takes one block per beat (first_block, block_high,
// block_low); o_res returns one result block per beat. Configuration goes
// through the APB port: key words, IV halves and mode at byte offsets 8*i.
// Write configuration only while the engine is idle.
// From accept to o_res.valid a beat without first_block passes through key
// fetch, initial key add, 14 rounds and output load. With first_block the
// key schedule runs first, one word per cycle through the S-box word unit:
// 2 rows copied plus 52 expanded words. The engine takes no new block until
// the result of the current one is loaded; i_blk.ready is high only in idle.
// The round datapath is shared by all rounds; round keys come from a 15-row
// memory, one row per cycle.
// Reset clears the state machine, output valid, chaining value and all
// configuration registers. The round-key memory is not cleared. When o_res
// stalls the result holds; the engine still takes the next block and
// parks the following result until the output register is free.
`default_nettype none
module aes256_block_modes (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    aes_blk_if.sink                        i_blk,
    aes_res_if.source                      o_res,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [aes_pkg::PADDR_W-1:0]    paddr,
    input  wire  [63:0]                    pwdata,
    output logic [63:0]                    prdata,
    output logic                           pready
);

    logic [63:0]  r_key [4];
    logic [63:0]  r_iv_high, r_iv_low;
    logic [2:0]   r_mode;

    aes_pkg::t_state r_state, n_state;
    logic [127:0] r_s, n_s;
    logic [127:0] r_blk, n_blk;
    logic [127:0] r_chain, n_chain;
    logic [127:0] r_res, n_res;
    logic         r_res_valid, n_res_valid;
    logic [3:0]   r_rnd, n_rnd;
    logic [aes_pkg::KIDX_W-1:0] r_kidx, n_kidx;
    logic [31:0]  r_win [8];
    logic [31:0]  n_win [8];
    logic [7:0]   r_rc, n_rc;

    logic [127:0] r_rk_mem [aes_pkg::KEY_ROWS];
    logic [127:0] r_rk;
    logic [aes_pkg::ROW_W-1:0] w_rd_row, w_wr_row;
    logic         w_wr_en;
    logic [127:0] w_wr_data;

    logic         w_dec;
    logic         w_wr;
    logic [2:0]   w_reg;
    logic         w_accept;
    logic [31:0]  w_t, w_new;
    logic [127:0] w_base, w_rnd_out;
    logic [3:0]   w_next_rnd;

    assign pready   = 1'b1;
    assign w_wr     = psel && penable && pwrite && pready;
    assign w_reg    = paddr[5:3];
    assign w_dec    = (r_mode == aes_pkg::MODE_ECB_DEC) || (r_mode == aes_pkg::MODE_CBC_DEC);
    assign w_accept = i_blk.valid && i_blk.ready;

    assign i_blk.ready  = (r_state == aes_pkg::ST_IDLE);
    assign o_res.valid  = r_res_valid;
    assign o_res.out_high = r_res[127:64];
    assign o_res.out_low  = r_res[63:0];

    always_comb begin
        case (w_reg)
            aes_pkg::REG_KEY0:    prdata = r_key[0];
            aes_pkg::REG_KEY1:    prdata = r_key[1];
            aes_pkg::REG_KEY2:    prdata = r_key[2];
            aes_pkg::REG_KEY3:    prdata = r_key[3];
            aes_pkg::REG_IV_HIGH: prdata = r_iv_high;
            aes_pkg::REG_IV_LOW:  prdata = r_iv_low;
            aes_pkg::REG_MODE:    prdata = {61'd0, r_mode};
            default:              prdata = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0]  <= '0;
            r_key[1]  <= '0;
            r_key[2]  <= '0;
            r_key[3]  <= '0;
            r_iv_high <= '0;
            r_iv_low  <= '0;
            r_mode    <= '0;
        end else if (w_wr) begin
            case (w_reg)
                aes_pkg::REG_KEY0:    r_key[0]  <= pwdata;
                aes_pkg::REG_KEY1:    r_key[1]  <= pwdata;
                aes_pkg::REG_KEY2:    r_key[2]  <= pwdata;
                aes_pkg::REG_KEY3:    r_key[3]  <= pwdata;
                aes_pkg::REG_IV_HIGH: r_iv_high <= pwdata;
                aes_pkg::REG_IV_LOW:  r_iv_low  <= pwdata;
                aes_pkg::REG_MODE:    r_mode    <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // key schedule word unit
    always_comb begin
        w_t = r_win[7];
        if (r_kidx[2:0] == 3'd0) begin
            w_t = aes_pkg::sbox_word({w_t[23:0], w_t[31:24]}) ^ {r_rc, 24'd0};
        end else if (r_kidx[2:0] == 3'd4) begin
            w_t = aes_pkg::sbox_word(w_t);
        end
        w_new = r_win[0] ^ w_t;
    end

    // round datapath
    always_comb begin
        if (w_dec) begin
            w_rnd_out = aes_pkg::inv_byte_sub_rows(r_s) ^ r_rk;
            if (r_rnd != 4'(aes_pkg::ROUND_COUNT)) w_rnd_out = aes_pkg::inv_mix(w_rnd_out);
        end else begin
            w_rnd_out = aes_pkg::byte_sub_rows(r_s);
            if (r_rnd != 4'(aes_pkg::ROUND_COUNT)) w_rnd_out = aes_pkg::mix(w_rnd_out);
            w_rnd_out = w_rnd_out ^ r_rk;
        end
        case (r_mode)
            aes_pkg::MODE_CBC_ENC: w_base = r_blk ^ r_chain;
            aes_pkg::MODE_CTR,
            aes_pkg::MODE_OFB:     w_base = r_chain;
            default:               w_base = r_blk;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_s         = r_s;
        n_blk       = r_blk;
        n_chain     = r_chain;
        n_res       = r_res;
        n_res_valid = r_res_valid;
        n_rnd       = r_rnd;
        n_kidx      = r_kidx;
        n_win       = r_win;
        n_rc        = r_rc;
        w_wr_en     = 1'b0;
        w_wr_row    = '0;
        w_wr_data   = {r_win[4], r_win[5], r_win[6], r_win[7]};
        w_next_rnd  = (r_state == aes_pkg::ST_PRE) ? 4'd0 : r_rnd + 4'd1;
        if (w_next_rnd > 4'(aes_pkg::ROUND_COUNT)) begin
            w_rd_row = '0;
        end else if (w_dec) begin
            w_rd_row = aes_pkg::ROW_W'(4'(aes_pkg::ROUND_COUNT) - w_next_rnd);
        end else begin
            w_rd_row = aes_pkg::ROW_W'(w_next_rnd);
        end

        if (o_res.valid && o_res.ready) n_res_valid = 1'b0;

        case (r_state)
            aes_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_blk = {i_blk.block_high, i_blk.block_low};
                    if (i_blk.first_block) begin
                        n_chain = {r_iv_high, r_iv_low};
                        n_win   = '{r_key[0][63:32], r_key[0][31:0], r_key[1][63:32],
                                    r_key[1][31:0], r_key[2][63:32], r_key[2][31:0],
                                    r_key[3][63:32], r_key[3][31:0]};
                        n_rc    = 8'h01;
                        n_kidx  = aes_pkg::KIDX_W'(8);
                        n_state = aes_pkg::ST_KROW0;
                    end else begin
                        n_state = aes_pkg::ST_PRE;
                    end
                end
            end
            aes_pkg::ST_KROW0: begin
                w_wr_en   = 1'b1;
                w_wr_row  = aes_pkg::ROW_W'(0);
                w_wr_data = {r_win[0], r_win[1], r_win[2], r_win[3]};
                n_state   = aes_pkg::ST_KROW1;
            end
            aes_pkg::ST_KROW1: begin
                w_wr_en   = 1'b1;
                w_wr_row  = aes_pkg::ROW_W'(1);
                w_wr_data = {r_win[4], r_win[5], r_win[6], r_win[7]};
                n_state   = aes_pkg::ST_KEXP;
            end
            aes_pkg::ST_KEXP: begin
                for (int i = 0; i < 7; i++) n_win[i] = r_win[i + 1];
                n_win[7] = w_new;
                if (r_kidx[2:0] == 3'd0) n_rc = aes_pkg::xtime(r_rc);
                if (r_kidx[1:0] == 2'd3) begin
                    w_wr_en   = 1'b1;
                    w_wr_row  = r_kidx[aes_pkg::KIDX_W-1:2];
                    w_wr_data = {r_win[5], r_win[6], r_win[7], w_new};
                end
                if (r_kidx == aes_pkg::KIDX_W'(aes_pkg::KEY_WORDS - 1)) begin
                    n_state = aes_pkg::ST_PRE;
                end else begin
                    n_kidx = r_kidx + 1'b1;
                end
            end
            aes_pkg::ST_PRE: begin
                n_rnd   = 4'd0;
                n_state = aes_pkg::ST_INIT;
            end
            aes_pkg::ST_INIT: begin
                n_s     = w_base ^ r_rk;
                n_rnd   = 4'd1;
                n_state = aes_pkg::ST_ROUND;
            end
            aes_pkg::ST_ROUND: begin
                n_s = w_rnd_out;
                if (r_rnd == 4'(aes_pkg::ROUND_COUNT)) begin
                    n_state = aes_pkg::ST_DONE;
                end else begin
                    n_rnd = r_rnd + 4'd1;
                end
            end
            aes_pkg::ST_DONE: begin
                if (!r_res_valid || o_res.ready) begin
                    n_res_valid = 1'b1;
                    n_state     = aes_pkg::ST_IDLE;
                    case (r_mode)
                        aes_pkg::MODE_ECB_ENC,
                        aes_pkg::MODE_ECB_DEC: n_res = r_s;
                        aes_pkg::MODE_CBC_ENC: begin
                            n_res   = r_s;
                            n_chain = r_s;
                        end
                        aes_pkg::MODE_CBC_DEC: begin
                            n_res   = r_s ^ r_chain;
                            n_chain = r_blk;
                        end
                        aes_pkg::MODE_CTR: begin
                            n_res   = r_blk ^ r_s;
                            n_chain = r_chain + 128'd1;
                        end
                        aes_pkg::MODE_OFB: begin
                            n_res   = r_blk ^ r_s;
                            n_chain = r_s;
                        end
                        default: n_res = '0;
                    endcase
                end
            end
            default: n_state = aes_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_rk_mem[w_wr_row] <= w_wr_data;
        r_rk <= r_rk_mem[w_rd_row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aes_pkg::ST_IDLE;
            r_res_valid <= 1'b0;
            r_chain     <= '0;
            r_rnd       <= '0;
            r_kidx      <= '0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            r_chain     <= n_chain;
            r_rnd       <= n_rnd;
            r_kidx      <= n_kidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s   <= n_s;
        r_blk <= n_blk;
        r_res <= n_res;
        r_win <= n_win;
        r_rc  <= n_rc;
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_blk.ready)
        else $error("engine ready right after accepting a block");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aes_pkg::ST_ROUND) |-> (r_rnd >= 4'd1 && r_rnd <= 4'(aes_pkg::ROUND_COUNT)))
        else $error("round counter out of range");

    a_kexp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aes_pkg::ST_KEXP) |->
            (r_kidx >= aes_pkg::KIDX_W'(8) && r_kidx <= aes_pkg::KIDX_W'(aes_pkg::KEY_WORDS - 1)))
        else $error("key word index out of range");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aes_pkg::ST_DONE && n_state == aes_pkg::ST_IDLE) |=> o_res.valid)
        else $error("finished block not presented");

    a_done_from_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == aes_pkg::ST_DONE) |-> $past(r_rnd) == 4'(aes_pkg::ROUND_COUNT))
        else $error("block finished before the last round");

endmodule
`default_nettype wire
